### hw/rtl/frs_pkg.sv
package frs_pkg;

  localparam int RUN_W         = 13;
  localparam int ROW_W         = 12;
  localparam int CENTRE_W      = 14;
  localparam int NUM_RUNS      = 5;
  localparam int CENTRE_RUN    = 2;
  localparam int SUM_W         = 16;
  localparam int TEST_W        = 22;
  localparam int END_W         = 17;
  localparam int CTR_W         = 20;
  localparam int MIN_TOTAL     = 7;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DEF_MAX_ROW_WIDTH = 4096;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef logic [NUM_RUNS-1:0][RUN_W-1:0] runs_t;

  typedef enum logic {
    JOB_EMIT,
    JOB_CHECK
  } job_kind_t;

  // One pending candidate: a test that already passed, or a row-end test
  // still to be done on the runs as they stood after the last pixel.
  typedef struct packed {
    job_kind_t          kind;
    logic [ROW_W-1:0]   row;
    logic [END_W-1:0]   end_pos;
    runs_t              runs;
  } job_t;

  // The 1:1:3:1:1 test in integers. With T the total and c one run,
  // |9T - 63c| < 5T means 4T < 63c < 14T, and |27T - 63c| < 15T means
  // 12T < 63c < 42T for the centre run.
  function automatic logic ratio_ok(input runs_t runs);
    logic [SUM_W-1:0]  total;
    logic [TEST_W-1:0] t_w;
    logic [TEST_W-1:0] c63;
    logic [TEST_W-1:0] lo;
    logic [TEST_W-1:0] hi;
    logic              ok;
    total = '0;
    ok = 1'b1;
    for (int k = 0; k < NUM_RUNS; k++) begin
      total = total + SUM_W'(runs[k]);
      if (runs[k] == '0) begin
        ok = 1'b0;
      end
    end
    if (total < SUM_W'(MIN_TOTAL)) begin
      ok = 1'b0;
    end
    t_w = TEST_W'(total);
    for (int k = 0; k < NUM_RUNS; k++) begin
      c63 = (TEST_W'(runs[k]) << 6) - TEST_W'(runs[k]);
      if (k == CENTRE_RUN) begin
        lo = (t_w << 3) + (t_w << 2);
        hi = (t_w << 5) + (t_w << 3) + (t_w << 1);
      end else begin
        lo = t_w << 2;
        hi = (t_w << 3) + (t_w << 2) + (t_w << 1);
      end
      if (!(c63 > lo && c63 < hi)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

### hw/rtl/frs_pix_if.sv
interface frs_pix_if
  import frs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             pixel_dark;
  logic             row_end;
  logic [ROW_W-1:0] row_index;

  modport source (output valid, output pixel_dark, output row_end, output row_index,
                  input ready);
  modport sink   (input valid, input pixel_dark, input row_end, input row_index,
                  output ready);
endinterface

### hw/rtl/frs_cand_if.sv
interface frs_cand_if
  import frs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    cand_row;
  logic [CENTRE_W-1:0] centre_half_px;
  logic [RUN_W-1:0]    run_a;
  logic [RUN_W-1:0]    run_b;
  logic [RUN_W-1:0]    run_c;
  logic [RUN_W-1:0]    run_d;
  logic [RUN_W-1:0]    run_e;
  logic [RUN_W-1:0]    run_total;

  modport source (output valid, output cand_row, output centre_half_px, output run_a,
                  output run_b, output run_c, output run_d, output run_e,
                  output run_total, input ready);
  modport sink   (input valid, input cand_row, input centre_half_px, input run_a,
                  input run_b, input run_c, input run_d, input run_e,
                  input run_total, output ready);
endinterface

### hw/rtl/finder_ratio_row_scanner.sv
// Finder pattern row scanner.
// in_ch carries one binarized pixel per word (pixel_dark, row_end, row_index);
// pixels of a row arrive left to right and row_end marks the last one.
// out_ch carries one word per finder candidate: the row, the centre in half
// pixels and the five run lengths with their total.
// Throughput is one pixel per cycle while the job queue is not full; the ratio
// test on the held runs is combinational and the run counters update on each accept.
// A candidate reaches out_ch by way of the job queue and the output register: the
// accepting edge writes the job queue, and the output register takes the job when it pops.
// The row-end test is evaluated on the way out, so a failing row-end check
// costs a queue slot but produces no word.
// When out_ch stalls, the output register holds its word and the two-entry
// job queue absorbs candidates; in_ch.ready drops only while the queue is
// full. Since at most one job arises per pixel and candidates are sparse,
// the pixel stream normally never sees backpressure.
// Synchronous reset clears the runs, the column and the queue; out_ch goes
// idle in the cycle after reset.
module finder_ratio_row_scanner
  import frs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  frs_pix_if.sink     in_ch,
  frs_cand_if.source  out_ch
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t pop_job;

  frs_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  frs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .job_valid (job_valid),
    .pop_job   (pop_job)
  );

  frs_back #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (pop_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

### hw/rtl/frs_front.sv
module frs_front
  import frs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  frs_pix_if.sink   in_ch,
  input  logic      q_full,
  output logic      push,
  output job_t      push_job
);

  localparam int COL_W = $clog2(MAX_ROW_WIDTH + 1);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_ROW_WIDTH);

  runs_t            cnt_r;
  runs_t            cnt_nxt;
  runs_t            cnt_upd;
  logic [2:0]       phase_r;
  logic [2:0]       phase_nxt;
  logic [2:0]       ph;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [COL_W-1:0] col_inc;
  logic             accept;
  logic             pass_now;
  logic             pass_hit;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pass_now    = ratio_ok(cnt_r);
  assign col_inc     = (col_r < COL_MAX) ? col_r + 1'b1 : col_r;

  always_comb begin
    cnt_upd   = cnt_r;
    phase_nxt = phase_r;
    pass_hit  = 1'b0;
    ph        = phase_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    if (accept) begin
      if (in_ch.pixel_dark) begin
        // A dark pixel after a light run opens the next dark run.
        ph = phase_r[0] ? phase_r + 3'd1 : phase_r;
        phase_nxt = ph;
        if (cnt_r[ph] != RUN_MAX) begin
          cnt_upd[ph] = cnt_r[ph] + 1'b1;
        end
      end else if (phase_r[0]) begin
        if (cnt_r[ph] != RUN_MAX) begin
          cnt_upd[ph] = cnt_r[ph] + 1'b1;
        end
      end else if (phase_r == 3'd4) begin
        if (pass_now) begin
          pass_hit  = 1'b1;
          cnt_upd   = '0;
          phase_nxt = '0;
        end else begin
          // Keep the last dark, light, dark runs as the first three.
          cnt_upd[0] = cnt_r[2];
          cnt_upd[1] = cnt_r[3];
          cnt_upd[2] = cnt_r[4];
          cnt_upd[3] = RUN_W'(1);
          cnt_upd[4] = '0;
          phase_nxt  = 3'd3;
        end
      end else begin
        ph = phase_r + 3'd1;
        phase_nxt = ph;
        if (cnt_r[ph] != RUN_MAX) begin
          cnt_upd[ph] = cnt_r[ph] + 1'b1;
        end
      end
      cnt_nxt = cnt_upd;
      col_nxt = col_inc;
      if (in_ch.row_end) begin
        cnt_nxt   = '0;
        phase_nxt = '0;
        col_nxt   = '0;
      end
    end
  end

  always_comb begin
    push              = accept && (pass_hit || in_ch.row_end);
    push_job.row      = in_ch.row_index;
    if (pass_hit) begin
      push_job.kind    = JOB_EMIT;
      push_job.end_pos = END_W'(col_r);
      push_job.runs    = cnt_r;
    end else begin
      push_job.kind    = JOB_CHECK;
      push_job.end_pos = END_W'(col_inc);
      push_job.runs    = cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= '0;
      col_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.row_end |=> col_r == '0 && phase_r == '0 && cnt_r == '0)
    else $error("row state not cleared after row end");
  a_emit_only_on_light_after_fifth: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_job.kind == JOB_EMIT |-> phase_r == 3'd4 && !in_ch.pixel_dark)
    else $error("candidate emitted outside the fifth run");
`endif

endmodule

### hw/rtl/frs_queue.sv
module frs_queue
  import frs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic job_valid,
  output job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign job_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");
  a_count_tracks_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a word");
`endif

endmodule

### hw/rtl/frs_back.sv
module frs_back
  import frs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        pop,
  frs_cand_if.source  out_ch
);

  localparam logic signed [CTR_W-1:0] CTR_MAX = CTR_W'(2 * MAX_ROW_WIDTH);
  localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'(RUN_MAX);

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      keep;
  logic signed [CTR_W-1:0]   ctr;
  logic signed [CTR_W-1:0]   ctr_clamp;
  logic [SUM_W-1:0]          total;
  logic [RUN_W-1:0]          total_sat;
  logic [ROW_W-1:0]          row_r;
  logic [CENTRE_W-1:0]       centre_r;
  runs_t                     runs_r;
  logic [RUN_W-1:0]          total_r;

  assign pop  = job_valid && (!out_valid_r || out_ch.ready);
  assign keep = (job.kind == JOB_EMIT) || ratio_ok(job.runs);

  always_comb begin
    // Centre in half pixels: twice the start of the fourth run, less the centre run.
    ctr = $signed(((CTR_W'(job.end_pos) - CTR_W'(job.runs[4]) - CTR_W'(job.runs[3])) << 1)
                  - CTR_W'(job.runs[2]));
    if (ctr < 0) begin
      ctr_clamp = '0;
    end else if (ctr > CTR_MAX) begin
      ctr_clamp = CTR_MAX;
    end else begin
      ctr_clamp = ctr;
    end
    total = '0;
    for (int k = 0; k < NUM_RUNS; k++) begin
      total = total + SUM_W'(job.runs[k]);
    end
    total_sat = (total > TOTAL_MAX) ? RUN_MAX : total[RUN_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = keep;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && keep) begin
      row_r    <= job.row;
      centre_r <= ctr_clamp[CENTRE_W-1:0];
      runs_r   <= job.runs;
      total_r  <= total_sat;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cand_row       = row_r;
  assign out_ch.centre_half_px = centre_r;
  assign out_ch.run_a          = runs_r[0];
  assign out_ch.run_b          = runs_r[1];
  assign out_ch.run_c          = runs_r[2];
  assign out_ch.run_d          = runs_r[3];
  assign out_ch.run_e          = runs_r[4];
  assign out_ch.run_total      = total_r;

`ifndef SYNTHESIS
  a_passed_job_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    pop && job.kind == JOB_EMIT |=> out_valid_r)
    else $error("passed candidate dropped");
`endif

endmodule
